// ----- design/fbc_pkg.sv -----
// ----------------------------------------------------------------------------
// fbc_pkg: shared types and constants for the frustum box culler
// Operation codes, the plane point count and fixed field widths.
// ----------------------------------------------------------------------------
package fbc_pkg;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TEST = 1'b1
    } op_t;

    localparam int PLANE_IDX_BITS  = 3;
    localparam int CORNER_IDX_BITS = 2;
    localparam int POINTS_PER_PLANE = 3;
    localparam int AXES = 3;
    localparam int LANE_STAGES = 6;

endpackage

// ----- design/fbc_lane.sv -----
// ----------------------------------------------------------------------------
// fbc_lane: one plane test
// Forms the plane normal from three points and tests both box corners
// against it over six registered stages.
// ----------------------------------------------------------------------------
module fbc_lane #(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic signed [COORD_BITS-1:0] p0 [fbc_pkg::AXES],
    input  logic signed [COORD_BITS-1:0] p1 [fbc_pkg::AXES],
    input  logic signed [COORD_BITS-1:0] p2 [fbc_pkg::AXES],
    input  logic signed [COORD_BITS-1:0] bmax [fbc_pkg::AXES],
    input  logic signed [COORD_BITS-1:0] bmin [fbc_pkg::AXES],
    output logic                         reject
);
    import fbc_pkg::*;

    localparam int DW   = COORD_BITS + 1;
    localparam int PW   = 2 * DW;
    localparam int NW   = PW + 1;
    localparam int LW   = NW / 2;
    localparam int HW   = NW - LW;
    localparam int PRW  = DW + NW;
    localparam int DOTW = PRW + 2;

    logic signed [DW-1:0]   e1_reg [AXES];
    logic signed [DW-1:0]   e2_reg [AXES];
    logic signed [DW-1:0]   tx_reg [AXES];
    logic signed [DW-1:0]   tn_reg [AXES];
    logic signed [DW-1:0]   tx2_reg [AXES];
    logic signed [DW-1:0]   tn2_reg [AXES];
    logic signed [DW-1:0]   tx3_reg [AXES];
    logic signed [DW-1:0]   tn3_reg [AXES];
    logic signed [PW-1:0]   cp_reg [6];
    logic signed [NW-1:0]   n_reg [AXES];
    logic signed [DW+LW:0]  xl_reg [AXES];
    logic signed [DW+HW-1:0] xh_reg [AXES];
    logic signed [DW+LW:0]  nl_reg [AXES];
    logic signed [DW+HW-1:0] nh_reg [AXES];
    logic signed [DOTW-1:0] dmax_reg;
    logic signed [DOTW-1:0] dmin_reg;
    logic                   reject_reg;

    logic signed [PRW-1:0]  xprod [AXES];
    logic signed [PRW-1:0]  nprod [AXES];
    logic signed [DOTW-1:0] dmax_next;
    logic signed [DOTW-1:0] dmin_next;

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < AXES; c++)
        begin
            e1_reg[c] <= DW'(p1[c]) - DW'(p0[c]);
            e2_reg[c] <= DW'(p2[c]) - DW'(p0[c]);
            tx_reg[c] <= DW'(bmax[c]) - DW'(p0[c]);
            tn_reg[c] <= DW'(bmin[c]) - DW'(p0[c]);
            tx2_reg[c] <= tx_reg[c];
            tn2_reg[c] <= tn_reg[c];
            tx3_reg[c] <= tx2_reg[c];
            tn3_reg[c] <= tn2_reg[c];
        end
        cp_reg[0] <= e1_reg[1] * e2_reg[2];
        cp_reg[1] <= e1_reg[2] * e2_reg[1];
        cp_reg[2] <= e1_reg[2] * e2_reg[0];
        cp_reg[3] <= e1_reg[0] * e2_reg[2];
        cp_reg[4] <= e1_reg[0] * e2_reg[1];
        cp_reg[5] <= e1_reg[1] * e2_reg[0];
        for (int c = 0; c < AXES; c++)
        begin
            n_reg[c] <= NW'(cp_reg[2*c]) - NW'(cp_reg[2*c+1]);
        end
        for (int c = 0; c < AXES; c++)
        begin
            xl_reg[c] <= tx3_reg[c] * $signed({1'b0, n_reg[c][LW-1:0]});
            xh_reg[c] <= tx3_reg[c] * $signed(n_reg[c][NW-1:LW]);
            nl_reg[c] <= tn3_reg[c] * $signed({1'b0, n_reg[c][LW-1:0]});
            nh_reg[c] <= tn3_reg[c] * $signed(n_reg[c][NW-1:LW]);
        end
        dmax_reg   <= dmax_next;
        dmin_reg   <= dmin_next;
        reject_reg <= (dmax_reg <= 0) && (dmin_reg <= 0);
    end

    always_comb
    begin
        for (int c = 0; c < AXES; c++)
        begin
            xprod[c] = (PRW'(xh_reg[c]) <<< LW) + PRW'(xl_reg[c]);
            nprod[c] = (PRW'(nh_reg[c]) <<< LW) + PRW'(nl_reg[c]);
        end
        dmax_next = DOTW'(xprod[0]) + DOTW'(xprod[1]) + DOTW'(xprod[2]);
        dmin_next = DOTW'(nprod[0]) + DOTW'(nprod[1]) + DOTW'(nprod[2]);
    end

    assign reject = reject_reg;

endmodule

// ----- design/frustum_box_cull.sv -----
// ----------------------------------------------------------------------------
// frustum_box_cull: axis-aligned box culling against stored frustum planes
// Loads plane points and tests boxes against all planes in parallel lanes.
// ----------------------------------------------------------------------------
// A load transaction yields no result.
// A test transaction's box is registered and passes through the six-stage lane
// pipeline and the merge register before its result is given; one test is in flight.
// No new transaction is accepted until the receiver has taken the test's result.
// Reset clears the control state; plane points are undefined until loaded.
module frustum_box_cull #(
    parameter int PLANE_COUNT = 6,
    parameter int COORD_BITS  = 24
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // plane_index, corner_index, point_x/y/z, max_x/y/z, min_x/y/z, zero pad
    input  logic [((5 + 9 * COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // operation
    input  logic s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // visible, zero pad
    output logic [7:0] m_axis_tdata
);
    import fbc_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int PX_LO = PLANE_IDX_BITS + CORNER_IDX_BITS;
    localparam int MX_LO = PX_LO + 3 * C;
    localparam int MN_LO = MX_LO + 3 * C;
    localparam int VLD_BITS = LANE_STAGES + 1;

    logic signed [C-1:0] pts_reg [PLANE_COUNT][POINTS_PER_PLANE][AXES];
    logic signed [C-1:0] bmax_reg [AXES];
    logic signed [C-1:0] bmin_reg [AXES];
    logic [VLD_BITS-1:0] vld_reg;
    logic [VLD_BITS-1:0] vld_next;
    logic                busy_reg;
    logic                busy_next;
    logic                out_vld_reg;
    logic                out_vld_next;
    logic                vis_reg;
    logic [PLANE_COUNT-1:0] reject;

    logic [PLANE_IDX_BITS-1:0]  plane_index;
    logic [CORNER_IDX_BITS-1:0] corner_index;
    op_t                        operation;
    logic                       in_xfer;
    logic                       load_xfer;
    logic                       test_xfer;

    assign plane_index  = s_axis_tdata[PLANE_IDX_BITS-1:0];
    assign corner_index = s_axis_tdata[PX_LO-1:PLANE_IDX_BITS];
    assign operation    = op_t'(s_axis_tuser);
    assign s_axis_tready = !busy_reg;
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign load_xfer = in_xfer && (operation == OP_LOAD);
    assign test_xfer = in_xfer && (operation == OP_TEST);

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < PLANE_COUNT; k++)
        begin
            for (int q = 0; q < POINTS_PER_PLANE; q++)
            begin
                if (load_xfer && (32'(plane_index) == k) && (32'(corner_index) == q))
                begin
                    for (int c = 0; c < AXES; c++)
                    begin
                        pts_reg[k][q][c] <= s_axis_tdata[PX_LO + c*C +: C];
                    end
                end
            end
        end
        if (test_xfer)
        begin
            for (int c = 0; c < AXES; c++)
            begin
                bmax_reg[c] <= s_axis_tdata[MX_LO + c*C +: C];
                bmin_reg[c] <= s_axis_tdata[MN_LO + c*C +: C];
            end
        end
        if (vld_reg[VLD_BITS-1])
        begin
            vis_reg <= ~|reject;
        end
    end

    for (genvar k = 0; k < PLANE_COUNT; k++)
    begin : g_lane
        fbc_lane #(
            .COORD_BITS(COORD_BITS)
        ) u_lane (
            .clk    (clk),
            .p0     (pts_reg[k][0]),
            .p1     (pts_reg[k][1]),
            .p2     (pts_reg[k][2]),
            .bmax   (bmax_reg),
            .bmin   (bmin_reg),
            .reject (reject[k])
        );
    end

    always_comb
    begin
        vld_next = {vld_reg[VLD_BITS-2:0], test_xfer};
        busy_next = busy_reg;
        out_vld_next = out_vld_reg;
        if (test_xfer)
        begin
            busy_next = 1'b1;
        end
        if (vld_reg[VLD_BITS-1])
        begin
            out_vld_next = 1'b1;
        end
        else if (out_vld_reg && m_axis_tready)
        begin
            out_vld_next = 1'b0;
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            busy_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg     <= vld_next;
            busy_reg    <= busy_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'd0, vis_reg};

    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> busy_reg)
        else $error("result pending while block is not busy");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({vld_reg, out_vld_reg}))
        else $error("more than one test in flight");

    a_pipe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg != '0) |-> busy_reg)
        else $error("test in pipeline while block is not busy");

endmodule

// ----- tb/tb_frustum_box_cull.sv -----
// ----------------------------------------------------------------------------
// tb_frustum_box_cull: self-checking testbench for the frustum box culler
// Loads plane points and streams test boxes with random idling on both sides,
// predicts each visibility result in the bench, and compares every result.
// ----------------------------------------------------------------------------
module tb_frustum_box_cull;

    timeunit 1ns;
    timeprecision 1ps;

    import fbc_pkg::*;

    localparam int PLANES = 6;
    localparam int CB = 24;
    localparam int DW = ((5 + 9 * CB + 7) / 8) * 8;
    localparam int LIMIT = 400000;

    typedef logic signed [CB-1:0] coord_t;

    typedef struct {
        op_t         op;
        logic [2:0]  plane;
        logic [1:0]  corner;
        coord_t      pt [3];
        coord_t      bmax [3];
        coord_t      bmin [3];
    } cull_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic s_axis_tready_q = 1'b0;

    cull_item_t pending_items[$];
    bit visible_expected[$];
    coord_t plane_pts [PLANES][3][3];
    int errors = 0;
    int cycles = 0;
    int idle_pct = 30;
    int hold_cycles = 0;
    bit stim_done = 1'b0;
    bit have_item = 1'b0;
    cull_item_t cur;

    frustum_box_cull u_top (.*);

    always #4 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic logic [DW-1:0] pack_item(input cull_item_t it);
        logic [DW-1:0] d;
        d = '0;
        d[2:0] = it.plane;
        d[4:3] = it.corner;
        for (int c = 0; c < 3; c++)
        begin
            d[5 + c * CB +: CB] = it.pt[c];
            d[5 + (3 + c) * CB +: CB] = it.bmax[c];
            d[5 + (6 + c) * CB +: CB] = it.bmin[c];
        end
        return d;
    endfunction

    // Applies an accepted item to the plane store and returns its visibility.
    function automatic bit cull_box(input cull_item_t it);
        logic signed [127:0] e1 [3], e2 [3], n [3], tx [3], tn [3], dx, dn;
        if (it.op == OP_LOAD)
        begin
            if (it.plane < PLANES && it.corner < 3)
                for (int c = 0; c < 3; c++)
                    plane_pts[it.plane][it.corner][c] = it.pt[c];
            return 1'b0;
        end
        for (int k = 0; k < PLANES; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                e1[c] = 128'(plane_pts[k][1][c]) - 128'(plane_pts[k][0][c]);
                e2[c] = 128'(plane_pts[k][2][c]) - 128'(plane_pts[k][0][c]);
                tx[c] = 128'(it.bmax[c]) - 128'(plane_pts[k][0][c]);
                tn[c] = 128'(it.bmin[c]) - 128'(plane_pts[k][0][c]);
            end
            n[0] = e1[1] * e2[2] - e1[2] * e2[1];
            n[1] = e1[2] * e2[0] - e1[0] * e2[2];
            n[2] = e1[0] * e2[1] - e1[1] * e2[0];
            dx = tx[0] * n[0] + tx[1] * n[1] + tx[2] * n[2];
            dn = tn[0] * n[0] + tn[1] * n[1] + tn[2] * n[2];
            if (dx <= 0 && dn <= 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic coord_t rand_coord(input int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'($urandom_range(0, 2000)) - coord_t'(1000);
            2: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
            default: return coord_t'($urandom_range(0, 131072)) - coord_t'(65536);
        endcase
    endfunction

    function automatic cull_item_t make_load(input int p, input int q, input int mode);
        cull_item_t it;
        it.op = OP_LOAD;
        it.plane = 3'(p);
        it.corner = 2'(q);
        for (int c = 0; c < 3; c++)
        begin
            it.pt[c] = rand_coord(mode);
            it.bmax[c] = coord_t'($urandom);
            it.bmin[c] = coord_t'($urandom);
        end
        return it;
    endfunction

    function automatic cull_item_t make_test(input int mode);
        cull_item_t it;
        it.op = OP_TEST;
        it.plane = 3'($urandom);
        it.corner = 2'($urandom);
        for (int c = 0; c < 3; c++)
        begin
            it.pt[c] = coord_t'($urandom);
            it.bmax[c] = rand_coord(mode);
            it.bmin[c] = rand_coord(mode);
        end
        return it;
    endfunction

    // Driver: offers items from the pending queue at the falling edge.
    always @(negedge clk)
    begin
        cycles++;
        if (have_item && s_axis_tvalid && s_axis_tready_q)
            have_item = 1'b0;
        if (!have_item && pending_items.size() > 0)
        begin
            cur = pending_items.pop_front();
            have_item = 1'b1;
        end
        if (rst_n && have_item && $urandom_range(0, 99) >= idle_pct)
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= pack_item(cur);
            s_axis_tuser <= cur.op;
        end
        else if (!(s_axis_tvalid && !s_axis_tready_q))
            s_axis_tvalid <= 1'b0;
        if (hold_cycles > 0)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= rst_n && ($urandom_range(0, 99) >= idle_pct);
    end

    // Receiver hold-off counter.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // Monitor: samples both handshakes at the rising edge.
    always @(posedge clk)
    begin
        s_axis_tready_q <= s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            if (cull_box(cur))
                visible_expected.push_back(1'b1);
            else if (cur.op == OP_TEST)
                visible_expected.push_back(1'b0);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (visible_expected.size() == 0)
                report_mismatch("result with none expected");
            else if (m_axis_tdata[0] !== visible_expected[0] || m_axis_tdata[7:1] !== 7'd0)
            begin
                report_mismatch($sformatf("visible got %b expected %b",
                    m_axis_tdata, visible_expected[0]));
                void'(visible_expected.pop_front());
            end
            else
                void'(visible_expected.pop_front());
        end
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic load_all_planes(input int mode);
        for (int p = 0; p < PLANES; p++)
            for (int q = 0; q < 3; q++)
                pending_items.push_back(make_load(p, q, mode));
    endtask

    initial
    begin
        cull_item_t it;
        int mode;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // Directed: full plane set, extreme boxes, ignored loads, degenerate plane.
        load_all_planes(1);
        it = make_test(2);
        pending_items.push_back(it);
        for (int c = 0; c < 3; c++)
        begin
            it.bmax[c] = 24'sh7fffff;
            it.bmin[c] = 24'sh800000;
        end
        pending_items.push_back(it);
        pending_items.push_back(make_load(6, 0, 2));
        pending_items.push_back(make_load(7, 1, 2));
        pending_items.push_back(make_load(2, 3, 2));
        it = make_load(0, 1, 0);
        it.pt = '{coord_t'(0), coord_t'(0), coord_t'(0)};
        pending_items.push_back(it);
        it.corner = 2'd0;
        pending_items.push_back(it);
        it.corner = 2'd2;
        pending_items.push_back(it);
        pending_items.push_back(make_test(1));
        for (int i = 0; i < 1050; i++)
        begin
            if (i == 300)
            begin
                wait (pending_items.size() == 0);
                hold_cycles = 200;
            end
            idle_pct = (i >= 500 && i < 700) ? 0 : 30;
            mode = $urandom_range(0, 3);
            if ($urandom_range(0, 199) < 1)
                load_all_planes(mode);
            else if ($urandom_range(0, 99) < 5)
                pending_items.push_back(make_load($urandom_range(0, 7),
                    $urandom_range(0, 3), mode));
            else
                pending_items.push_back(make_test(mode));
            while (pending_items.size() > 8)
                @(posedge clk);
        end
        wait (pending_items.size() == 0 && !have_item);
        wait (visible_expected.size() == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
